>>> rtl/rkf_pkg.sv
`default_nettype none
package rkf_pkg;

  localparam int TAPS  = 5;
  localparam int REACH = TAPS / 2;
  localparam int WFRAC = 14;
  localparam int LAT   = 10;

  localparam logic [1:0] KIND_BOX   = 2'd0;
  localparam logic [1:0] KIND_TENT  = 2'd1;
  localparam logic [1:0] KIND_BELL  = 2'd2;
  localparam logic [1:0] KIND_MITCH = 2'd3;

  localparam logic [1:0] REG_KIND = 2'd0;
  localparam logic [1:0] REG_ZOOM = 2'd1;
  localparam logic [1:0] REG_INV  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_LOAD
  } rkf_state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [18:0] x;
    logic [23:0]        px;
    logic               ok;
  } rkf_lane_in_t;

  typedef struct packed {
    logic signed [24:0] r;
    logic signed [24:0] g;
    logic signed [24:0] b;
  } rkf_lane_out_t;

endpackage
`default_nettype wire

>>> rtl/rkf_lane.sv
`default_nettype none
module rkf_lane import rkf_pkg::*; (
  input  wire logic    clk,
  input  rkf_lane_in_t lin,
  output rkf_lane_out_t lout
);

  logic [17:0]        a_abs;
  logic signed [18:0] x1;
  logic [17:0]        a1;
  logic signed [19:0] t1;
  logic [23:0]        px1;
  logic               ok1;
  logic [1:0]         kind1;
  logic [35:0]        a2;
  logic signed [39:0] tsq;
  logic [53:0]        a3;
  logic signed [15:0] wsimp;
  logic signed [15:0] wsimp_next;
  logic signed [57:0] a3s;
  logic signed [57:0] a2s;
  logic signed [57:0] as1;
  logic signed [57:0] n_in;
  logic signed [57:0] n_out;
  logic signed [57:0] nr;
  logic signed [57:0] nabs;
  logic               neg5;
  logic [19:0]        q5;
  logic [37:0]        prod6;
  logic [15:0]        wm;
  logic signed [15:0] w7;
  logic signed [15:0] w7_next;
  logic [31:0]        bell_in;

  always_comb begin
    a_abs = lin.x[18] ? 18'(-lin.x) : 18'(lin.x);
  end

  always_ff @(posedge clk) begin
    x1    <= lin.x;
    a1    <= a_abs;
    t1    <= $signed({1'b0, a_abs, 1'b0}) - 20'sd196608;
    px1   <= lin.px;
    ok1   <= lin.ok;
    kind1 <= lin.kind;
  end

  always_ff @(posedge clk) begin
    a2  <= 36'(a1) * 36'(a1);
    tsq <= 40'(t1) * 40'(t1);
  end

  always_comb begin
    bell_in    = 32'hC000_0000 - a2[31:0];
    wsimp_next = '0;
    case (kind1)
      KIND_BOX: begin
        if (x1 >= -19'sd32768 && x1 < 19'sd32768) wsimp_next = 16'sd16384;
      end
      KIND_TENT: begin
        if (a1 <= 18'd65536) wsimp_next = $signed({1'b0, 15'((18'd65536 - a1) >> 2)});
      end
      KIND_BELL: begin
        if (a1 <= 18'd32768) wsimp_next = $signed({2'b00, bell_in[31:18]});
        else if (a1 <= 18'd98304) wsimp_next = $signed(tsq[36:21]);
      end
      default: wsimp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    a3    <= 54'(a2) * 54'(a1);
    wsimp <= wsimp_next;
  end

  always_comb begin
    a3s   = $signed({4'b0, a3});
    a2s   = $signed({22'b0, a2});
    as1   = $signed({40'b0, a1});
    n_in  = 58'sd21 * a3s - ((58'sd36 * a2s) <<< 16) + (58'sd1 <<< 52);
    n_out = (58'sd1 <<< 53) - 58'sd7 * a3s + ((58'sd36 * a2s) <<< 16)
            - ((58'sd60 * as1) <<< 32);
  end

  always_ff @(posedge clk) begin
    nr <= (a1 <= 18'd65536) ? n_in : n_out;
  end

  always_comb begin
    nabs = nr[57] ? -nr : nr;
  end

  always_ff @(posedge clk) begin
    neg5  <= nr[57];
    q5    <= nabs[53:34];
    prod6 <= 38'(q5[19:1]) * 38'd233017;
  end

  always_comb begin
    wm = prod6[36:21];
    if (kind1 == KIND_MITCH) begin
      if (a1 > 18'd131072) w7_next = '0;
      else w7_next = neg5 ? -$signed(wm) : $signed(wm);
    end else begin
      w7_next = wsimp;
    end
  end

  always_ff @(posedge clk) begin
    w7 <= w7_next;
    if (ok1) begin
      lout.r <= w7 * $signed({1'b0, px1[7:0]});
      lout.g <= w7 * $signed({1'b0, px1[15:8]});
      lout.b <= w7 * $signed({1'b0, px1[23:16]});
    end else begin
      lout <= '0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rkf_merge.sv
`default_nettype none
module rkf_merge import rkf_pkg::*; (
  input  wire logic                     clk,
  input  rkf_lane_out_t [TAPS-1:0]      lanes,
  output logic [23:0]                   rgb
);

  logic signed [27:0] sr;
  logic signed [27:0] sg;
  logic signed [27:0] sb;
  logic signed [27:0] sr_next;
  logic signed [27:0] sg_next;
  logic signed [27:0] sb_next;

  function automatic logic [7:0] finish(input logic signed [27:0] s);
    logic [7:0] v;
    if (s < 0) v = 8'd0;
    else if (s[27:WFRAC] > 14'd255) v = 8'd255;
    else v = s[WFRAC+7:WFRAC];
    return v;
  endfunction

  always_comb begin
    sr_next = '0;
    sg_next = '0;
    sb_next = '0;
    for (int i = 0; i < TAPS; i++) begin
      sr_next = sr_next + 28'(lanes[i].r);
      sg_next = sg_next + 28'(lanes[i].g);
      sb_next = sb_next + 28'(lanes[i].b);
    end
  end

  always_ff @(posedge clk) begin
    sr  <= sr_next;
    sg  <= sg_next;
    sb  <= sb_next;
    rgb <= {finish(sb), finish(sg), finish(sr)};
  end

endmodule
`default_nettype wire

>>> rtl/row_upscale_kernel_filter_core.sv
`default_nettype none
// Horizontal row upscaler: each input pixel of a row yields zoom_factor output pixels, filtered
// with a box, tent, quadratic bell or Mitchell kernel over five taps. Block k goes out when
// pixel k+2 arrives; the row-end pixel flushes the rest (up to three blocks). Every output
// pixel passes through a 10-stage multicycle datapath (five tap lanes plus a merge) and the
// load state, which waits while the output side stalls; no new pixel is taken until the last
// output of the current one is loaded. The first two pixels of a longer row emit nothing.
module row_upscale_kernel_filter_core import rkf_pkg::*; #(
  parameter int MAX_FACTOR     = 16,
  parameter int MAX_ROW_PIXELS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // out_red, out_green, out_blue
  output logic             m_axis_tlast,
  output logic [0:0]       m_axis_tuser    // output_row_end
);

  localparam int IW = $clog2(MAX_ROW_PIXELS);
  localparam int MW = $clog2(MAX_FACTOR);
  localparam int CW = $clog2(LAT);

  rkf_state_t state, state_next;

  logic [1:0]  kernel_kind;
  logic [4:0]  zoom_factor;
  logic [15:0] inverse_factor;
  logic [4:0]  fac;
  logic [4:0]  fac_r;

  logic [23:0] window [TAPS];
  logic [IW-1:0] pixel_index;
  logic [IW-1:0] next_block;
  logic [IW-1:0] cur;
  logic [IW-1:0] blk;
  logic [IW-1:0] blk_last;
  logic          end_r;
  logic [MW-1:0] m;
  logic [CW-1:0] cnt;

  logic          in_end;
  logic          has_res;
  logic          last_out;
  logic          load;
  logic [MW+15:0] prod_p;
  logic [15:0]   p;
  logic [23:0]   rgb;

  rkf_lane_in_t  [TAPS-1:0] lane_in;
  rkf_lane_out_t [TAPS-1:0] lane_out;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_KIND: prdata = {30'b0, kernel_kind};
      REG_ZOOM: prdata = {27'b0, zoom_factor};
      REG_INV:  prdata = {16'b0, inverse_factor};
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    if (zoom_factor < 5'd2) fac = 5'd2;
    else if (zoom_factor > 5'(MAX_FACTOR)) fac = 5'(MAX_FACTOR);
    else fac = zoom_factor;
  end

  always_comb begin
    prod_p = (MW+16)'(m) * (MW+16)'(inverse_factor);
    p      = (prod_p > (MW+16)'(65535)) ? 16'hFFFF : prod_p[15:0];
  end

  for (genvar i = 0; i < TAPS; i++) begin : g_lane
    logic signed [IW+1:0] tap;
    logic [IW-1:0]        tapc;
    logic [IW-1:0]        age;
    logic                 age_ok;
    logic [2:0]           sel;

    always_comb begin
      tap    = $signed({2'b00, blk}) + (IW+2)'(i - REACH);
      tapc   = (tap > $signed({2'b00, cur})) ? cur : tap[IW-1:0];
      age    = cur - tapc;
      age_ok = !tap[IW+1] && (age < IW'(TAPS));
      sel    = age_ok ? age[2:0] : 3'd0;
      lane_in[i].kind = kernel_kind;
      lane_in[i].x    = 19'((i - REACH) * 65536) - 19'(p);
      lane_in[i].px   = window[sel];
      lane_in[i].ok   = age_ok;
    end

    rkf_lane u_lane (
      .clk  (clk),
      .lin  (lane_in[i]),
      .lout (lane_out[i])
    );
  end

  rkf_merge u_merge (
    .clk   (clk),
    .lanes (lane_out),
    .rgb   (rgb)
  );

  always_comb begin
    in_end        = s_axis_tlast || (pixel_index >= IW'(MAX_ROW_PIXELS - 1));
    has_res       = in_end || (pixel_index >= IW'(REACH));
    last_out      = (5'(m) + 5'd1 == fac_r) && (blk == blk_last);
    load          = (state == S_LOAD) && (!m_axis_tvalid || m_axis_tready);
    s_axis_tready = (state == S_IDLE);
    state_next    = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && has_res) state_next = S_CALC;
      end
      S_CALC: begin
        if (cnt == CW'(LAT - 1)) state_next = S_LOAD;
      end
      S_LOAD: begin
        if (load) state_next = last_out ? S_IDLE : S_CALC;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      kernel_kind    <= 2'd1;
      zoom_factor    <= 5'd2;
      inverse_factor <= 16'd32768;
      pixel_index    <= '0;
      next_block     <= '0;
      m_axis_tvalid  <= 1'b0;
      cnt            <= '0;
      m              <= '0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_KIND: kernel_kind    <= pwdata[1:0];
          REG_ZOOM: zoom_factor    <= pwdata[4:0];
          REG_INV:  inverse_factor <= pwdata[15:0];
          default: ;
        endcase
      end
      if (load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

      if (state == S_IDLE && s_axis_tvalid) begin
        cur   <= pixel_index;
        end_r <= in_end;
        fac_r <= fac;
        m     <= '0;
        cnt   <= '0;
        if (in_end) begin
          blk         <= next_block;
          blk_last    <= pixel_index;
          pixel_index <= '0;
          next_block  <= '0;
        end else begin
          pixel_index <= pixel_index + 1'b1;
          if (has_res) begin
            blk        <= pixel_index - IW'(REACH);
            blk_last   <= pixel_index - IW'(REACH);
            next_block <= pixel_index - IW'(REACH - 1);
          end
        end
      end
      if (state == S_CALC) cnt <= cnt + 1'b1;
      if (load) begin
        cnt <= '0;
        if (5'(m) + 5'd1 == fac_r) begin
          m   <= '0;
          blk <= blk + 1'b1;
        end else begin
          m <= m + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      window[0] <= s_axis_tdata;
      for (int i = 1; i < TAPS; i++) window[i] <= window[i-1];
    end
    if (load) begin
      m_axis_tdata    <= rgb;
      m_axis_tlast    <= last_out;
      m_axis_tuser[0] <= end_r && last_out;
    end
  end

`ifndef SYNTHESIS
  a_row_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("row end without run end");

  a_blk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (blk <= blk_last))
    else $error("block counter past last block");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    pixel_index <= IW'(MAX_ROW_PIXELS - 1))
    else $error("pixel index past row limit");

  a_no_out_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && s_axis_tvalid && !has_res) |=> (state == S_IDLE))
    else $error("silent pixel started a calculation");
`endif

endmodule
`default_nettype wire
